>>> hdl/dtdb_pkg.sv
// Shared types, constants and status codes of the transfer descriptor builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtdb_pkg;

  localparam int DESCRIPTOR_COUNT = 8;
  localparam int ENDPOINT_SLOTS   = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int N_PAGES          = 5;

  localparam int EP_W    = 5;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 20;
  localparam int HEAD_W  = 13;
  localparam int LEN_W   = 15;

  localparam logic [31:0]        TERMINATOR     = 32'hDEAD0001;
  localparam logic [31:0]        TOKEN_ACTIVE   = 32'h0000_0080;
  localparam logic [11:0]        PAGE_MASK      = 12'hfff;
  localparam logic [COUNT_W-1:0] PAGE_BYTES     = 20'd4096;
  localparam logic [COUNT_W-1:0] DESC_MAX_BYTES = 20'd20480;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_EP     = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_NO_DESC    = 2'd3
  } status_t;

  typedef enum logic {
    CFG_DESC_BASE = 1'b0,
    CFG_BOUNCE    = 1'b1
  } cfg_index_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic               bad;
    logic [31:0]        prime;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [HEAD_W-1:0]  head;
  } req_entry_t;

  typedef struct packed {
    logic       push;
    req_entry_t entry;
  } queue_wr_t;

  typedef struct packed {
    logic       valid;
    req_entry_t entry;
  } queue_rd_t;

endpackage

`default_nettype wire

>>> hdl/dtdb_if.sv
// Valid/ready channel interfaces: transfer requests in, descriptors out.
// Depends on dtdb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtdb_req_if;
  logic                         valid;
  logic                         ready;
  logic [dtdb_pkg::EP_W-1:0]    endpoint;
  logic [dtdb_pkg::ADDR_W-1:0]  buffer_address;
  logic [dtdb_pkg::COUNT_W-1:0] byte_count;

  modport source (output valid, endpoint, buffer_address, byte_count, input ready);
  modport sink   (input valid, endpoint, buffer_address, byte_count, output ready);
endinterface

interface dtdb_td_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_word;
  logic [31:0] token_word;
  logic [31:0] page_zero;
  logic [31:0] page_one;
  logic [31:0] page_two;
  logic [31:0] page_three;
  logic [31:0] page_four;
  logic        last;
  logic [1:0]  status;
  logic [31:0] prime_mask;

  modport source (output valid, next_word, token_word, page_zero, page_one, page_two,
                  page_three, page_four, last, status, prime_mask, input ready);
  modport sink   (input valid, next_word, token_word, page_zero, page_one, page_two,
                  page_three, page_four, last, status, prime_mask, output ready);
endinterface

`default_nettype wire

>>> hdl/dtdb_front.sv
// Front end: takes requests, checks the endpoint, works out prime bit and
// bounce head, and pushes the result into the queue. Depends on dtdb_pkg, dtdb_if.
`timescale 1ns / 1ps
`default_nettype none

module dtdb_front (
  dtdb_req_if.sink              req,
  input  wire logic             queue_full,
  output dtdb_pkg::queue_wr_t   wr
);

  logic [11:0]                 offset;
  logic [dtdb_pkg::HEAD_W-1:0] head;
  logic [4:0]                  prime_bit;

  assign req.ready = !queue_full;
  assign offset    = req.buffer_address[11:0];
  // OUT slot n -> bit n/2, IN slot n -> bit 16 + (n-1)/2
  assign prime_bit = {req.endpoint[0], req.endpoint[4:1]};

  always_comb begin
    head = '0;
    if (offset != 12'd0) begin
      if (req.byte_count > dtdb_pkg::PAGE_BYTES) begin
        head = dtdb_pkg::HEAD_W'(dtdb_pkg::PAGE_BYTES) - {1'b0, offset};
      end else begin
        head = req.byte_count[dtdb_pkg::HEAD_W-1:0];
      end
    end
  end

  always_comb begin
    wr.push        = req.valid && !queue_full;
    wr.entry.bad   = {1'b0, req.endpoint} >= 6'(dtdb_pkg::ENDPOINT_SLOTS);
    wr.entry.prime = 32'd1 << prime_bit;
    wr.entry.addr  = req.buffer_address;
    wr.entry.count = req.byte_count;
    wr.entry.head  = head;
  end

endmodule

`default_nettype wire

>>> hdl/dtdb_queue.sv
// Short queue of classified requests between front and back end.
// Depends on dtdb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtdb_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dtdb_pkg::queue_wr_t  wr,
  input  wire logic                 pop,
  output logic                      full,
  output dtdb_pkg::queue_rd_t       rd
);

  localparam int PTR_W = $clog2(dtdb_pkg::QUEUE_DEPTH);

  dtdb_pkg::req_entry_t mem [dtdb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       fill;
  logic                 do_pop;

  assign full     = fill == (PTR_W + 1)'(dtdb_pkg::QUEUE_DEPTH);
  assign rd.valid = fill != '0;
  assign rd.entry = mem[rd_ptr];
  assign do_pop   = pop && rd.valid;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(dtdb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(dtdb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr.push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/dtdb_back.sv
// Back end: walks a request page by page, builds descriptors and error
// results, and holds them in the output register. Depends on dtdb_pkg, dtdb_if.
`timescale 1ns / 1ps
`default_nettype none

module dtdb_back #(
  parameter int DESCRIPTOR_COUNT = dtdb_pkg::DESCRIPTOR_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          desc_base,
  input  wire logic [31:0]          bounce_addr,
  input  wire dtdb_pkg::queue_rd_t  rd,
  output logic                      pop,
  dtdb_td_if.source                 td
);

  localparam int IDX_W = $clog2(DESCRIPTOR_COUNT + 1);
  localparam int N_W   = $clog2(dtdb_pkg::N_PAGES);

  typedef enum logic [1:0] {S_IDLE, S_PAGE, S_EMIT, S_ERR} state_t;

  state_t                       state;
  logic [dtdb_pkg::COUNT_W-1:0] rem;
  logic [31:0]                  ptr;
  logic [dtdb_pkg::HEAD_W-1:0]  head;
  logic [IDX_W-1:0]             idx;
  logic [N_W-1:0]               n;
  logic [31:0]                  pages [dtdb_pkg::N_PAGES];
  logic [dtdb_pkg::LEN_W-1:0]   tok_len;
  logic                         ioc;
  logic                         final_desc;
  logic [31:0]                  prime;
  dtdb_pkg::status_t            err_status;

  logic                         out_valid;
  logic                         slot_free;
  logic                         load_out;
  logic                         at_limit;
  logic [IDX_W-1:0]             idx_inc;
  logic [31:0]                  pg;
  logic [31:0]                  ptr_next;
  logic [dtdb_pkg::COUNT_W-1:0] rem_next;
  logic [dtdb_pkg::LEN_W-1:0]   len_from_rem;
  logic [dtdb_pkg::LEN_W-1:0]   len_from_entry;

  assign td.valid  = out_valid;
  assign slot_free = !out_valid || td.ready;
  assign load_out  = slot_free && ((state == S_EMIT) || (state == S_ERR));
  assign pop       = (state == S_IDLE) && rd.valid;
  assign at_limit  = idx == IDX_W'(DESCRIPTOR_COUNT - 1);
  assign idx_inc   = idx + 1'b1;

  assign len_from_rem   = (rem > dtdb_pkg::DESC_MAX_BYTES) ?
                          dtdb_pkg::DESC_MAX_BYTES[dtdb_pkg::LEN_W-1:0] :
                          rem[dtdb_pkg::LEN_W-1:0];
  assign len_from_entry = (rd.entry.count > dtdb_pkg::DESC_MAX_BYTES) ?
                          dtdb_pkg::DESC_MAX_BYTES[dtdb_pkg::LEN_W-1:0] :
                          rd.entry.count[dtdb_pkg::LEN_W-1:0];

  always_comb begin
    if (head != '0) begin
      pg       = bounce_addr;
      ptr_next = ptr + 32'(head);
      rem_next = rem - dtdb_pkg::COUNT_W'(head);
    end else if (rem >= dtdb_pkg::PAGE_BYTES) begin
      pg       = ptr;
      ptr_next = ptr + 32'(dtdb_pkg::PAGE_BYTES);
      rem_next = rem - dtdb_pkg::PAGE_BYTES;
    end else begin
      pg       = ptr;
      ptr_next = ptr + 32'(rem);
      rem_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (td.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (rd.valid) begin
            prime      <= rd.entry.prime;
            rem        <= rd.entry.count;
            ptr        <= rd.entry.addr;
            head       <= rd.entry.head;
            idx        <= '0;
            n          <= '0;
            tok_len    <= len_from_entry;
            ioc        <= rd.entry.count == '0;
            final_desc <= rd.entry.count == '0;
            for (int i = 0; i < dtdb_pkg::N_PAGES; i++) begin
              pages[i] <= '0;
            end
            if (rd.entry.bad) begin
              err_status <= dtdb_pkg::ST_BAD_EP;
              state      <= S_ERR;
            end else if (rd.entry.count == '0) begin
              state      <= S_EMIT;
            end else begin
              state <= S_PAGE;
            end
          end
        end
        S_PAGE: begin
          pages[n] <= pg;
          rem      <= rem_next;
          ptr      <= ptr_next;
          head     <= '0;
          if ((pg[11:0] & dtdb_pkg::PAGE_MASK) != 12'd0) begin
            err_status <= dtdb_pkg::ST_MISALIGNED;
            state      <= S_ERR;
          end else if (rem_next == '0) begin
            ioc        <= 1'b1;
            final_desc <= 1'b1;
            state      <= S_EMIT;
          end else if (n == N_W'(dtdb_pkg::N_PAGES - 1)) begin
            state <= S_EMIT;
          end else begin
            n <= n + 1'b1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            td.next_word  <= (final_desc || at_limit) ? dtdb_pkg::TERMINATOR :
                             desc_base + 32'({idx_inc, 5'b0});
            td.token_word <= dtdb_pkg::TOKEN_ACTIVE | {1'b0, tok_len, ioc, 15'b0};
            td.page_zero  <= pages[0];
            td.page_one   <= pages[1];
            td.page_two   <= pages[2];
            td.page_three <= pages[3];
            td.page_four  <= pages[4];
            td.last       <= final_desc;
            td.status     <= dtdb_pkg::ST_OK;
            td.prime_mask <= final_desc ? prime : 32'd0;
            if (final_desc) begin
              state <= S_IDLE;
            end else if (at_limit) begin
              err_status <= dtdb_pkg::ST_NO_DESC;
              state      <= S_ERR;
            end else begin
              idx     <= idx_inc;
              n       <= '0;
              tok_len <= len_from_rem;
              for (int i = 0; i < dtdb_pkg::N_PAGES; i++) begin
                pages[i] <= '0;
              end
              state <= S_PAGE;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            td.next_word  <= '0;
            td.token_word <= '0;
            td.page_zero  <= '0;
            td.page_one   <= '0;
            td.page_two   <= '0;
            td.page_three <= '0;
            td.page_four  <= '0;
            td.last       <= 1'b1;
            td.status     <= err_status;
            td.prime_mask <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/dma_transfer_descriptor_builder_core.sv
// Top level of the transfer descriptor builder: configuration registers,
// front end, request queue and back end. Depends on dtdb_pkg, dtdb_if and submodules.
`timescale 1ns / 1ps
`default_nettype none

// Each request (endpoint, buffer address, byte count) becomes a chain of
// transfer descriptors on td, one transfer per descriptor, the last one flagged
// and carrying the endpoint prime mask; failures end the chain with an error
// result. Requests are taken into a two-entry queue whenever it has room, so
// the request side runs ahead of the descriptor side. The back end takes a
// request while idle, walks the buffer one page at a time, then emits each
// descriptor, or an error result on a failure. A zero-length request goes
// straight to its one descriptor and a rejected request straight to its error
// result; a chain that runs out after eight descriptors ends in an error
// result. While td holds off a result, the back end waits to emit the next.
module dma_transfer_descriptor_builder_core #(
  parameter int DESCRIPTOR_COUNT = dtdb_pkg::DESCRIPTOR_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  dtdb_req_if.sink         req,
  dtdb_td_if.source        td
);

  logic [31:0]         desc_base;
  logic [31:0]         bounce_addr;
  dtdb_pkg::queue_wr_t q_wr;
  dtdb_pkg::queue_rd_t q_rd;
  logic                q_full;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_base   <= '0;
      bounce_addr <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtdb_pkg::CFG_DESC_BASE: desc_base   <= cfg_data;
        dtdb_pkg::CFG_BOUNCE:    bounce_addr <= cfg_data;
        default:                 desc_base   <= desc_base;
      endcase
    end
  end

  dtdb_front u_front (
    .req        (req),
    .queue_full (q_full),
    .wr         (q_wr)
  );

  dtdb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (q_pop),
    .full (q_full),
    .rd   (q_rd)
  );

  dtdb_back #(
    .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .desc_base   (desc_base),
    .bounce_addr (bounce_addr),
    .rd          (q_rd),
    .pop         (q_pop),
    .td          (td)
  );

endmodule

`default_nettype wire

>>> hdl/dtdb_checker.sv
// Port-level checks on the descriptor output, bound to the top level.
// Depends on dtdb_pkg and dma_transfer_descriptor_builder_core.
`timescale 1ns / 1ps
`default_nettype none

module dtdb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        td_valid,
  input wire logic        td_ready,
  input wire logic [31:0] td_next_word,
  input wire logic [31:0] td_token_word,
  input wire logic [31:0] td_page_zero,
  input wire logic        td_last,
  input wire logic [1:0]  td_status,
  input wire logic [31:0] td_prime_mask
);

  a_error_ends_chain: assert property (@(posedge clk) disable iff (rst)
    td_valid && td_status != dtdb_pkg::ST_OK |-> td_last)
    else $error("error result without last");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    td_valid && td_status != dtdb_pkg::ST_OK |->
      td_next_word == 32'd0 && td_token_word == 32'd0 && td_page_zero == 32'd0 &&
      td_prime_mask == 32'd0)
    else $error("error result carries data");

  a_prime_only_on_last: assert property (@(posedge clk) disable iff (rst)
    td_valid && !td_last |-> td_prime_mask == 32'd0 && td_status == dtdb_pkg::ST_OK)
    else $error("prime mask before end of chain");

  a_descriptor_active: assert property (@(posedge clk) disable iff (rst)
    td_valid && td_status == dtdb_pkg::ST_OK |->
      td_token_word[7] && (td_last == td_token_word[15]))
    else $error("descriptor token malformed");

  a_td_hold: assert property (@(posedge clk) disable iff (rst)
    td_valid && !td_ready |=> td_valid && $stable(td_token_word))
    else $error("transfer dropped while stalled");

endmodule

bind dma_transfer_descriptor_builder_core dtdb_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .td_valid      (td.valid),
  .td_ready      (td.ready),
  .td_next_word  (td.next_word),
  .td_token_word (td.token_word),
  .td_page_zero  (td.page_zero),
  .td_last       (td.last),
  .td_status     (td.status),
  .td_prime_mask (td.prime_mask)
);

`default_nettype wire
